// ===== hdl/usd_pkg.sv =====
// Package for the UTF-8 stream decoder: beat types, queue entry type and constants.
// Depends on nothing; every other file imports it.
package usd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [30:0] REPL_CHAR = 31'd63;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [30:0] code_point;
        logic        is_replacement;
        logic        last_of_run;
    } t_out_beat;

    // One queue entry holds every result that one accepted byte caused.
    typedef struct packed {
        logic [1:0] count;
        t_out_beat  res0;
        t_out_beat  res1;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/usd_front.sv =====
// Front end of the UTF-8 stream decoder: accepts bytes, keeps the decode state
// and pushes the results of each byte into the queue. Depends on usd_pkg.
module usd_front import usd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    input  t_q_status i_q_status,
    output t_q_push   o_push
);

    logic [2:0]  r_pending, n_pending;
    logic [30:0] r_partial, n_partial;
    logic        r_skip,    n_skip;

    logic        accept;
    logic [7:0]  b;
    logic        cont;
    t_entry      ent;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign b          = i_in_beat.data_byte;
    assign cont       = (b[7:6] == 2'b10);

    always_comb begin
        logic [30:0] vals [2];
        logic        reps [2];
        logic [1:0]  cnt;
        logic        do_lead;
        logic [30:0] shifted;

        vals[0]   = '0;
        vals[1]   = '0;
        reps[0]   = 1'b0;
        reps[1]   = 1'b0;
        cnt       = 2'd0;
        do_lead   = 1'b0;
        shifted   = {r_partial[24:0], b[5:0]};
        n_pending = r_pending;
        n_partial = r_partial;
        n_skip    = r_skip;

        if (r_pending != 3'd0) begin
            if (cont) begin
                n_pending = r_pending - 3'd1;
                n_partial = shifted;
                if (r_pending == 3'd1) begin
                    vals[0]   = shifted;
                    cnt       = 2'd1;
                    n_partial = '0;
                end
            end else begin
                // Broken sequence: replace it, then take this byte as a lead.
                vals[0]   = REPL_CHAR;
                reps[0]   = 1'b1;
                cnt       = 2'd1;
                n_pending = 3'd0;
                n_partial = '0;
                do_lead   = 1'b1;
            end
        end else if (cont) begin
            if (!r_skip) begin
                vals[0] = REPL_CHAR;
                reps[0] = 1'b1;
                cnt     = 2'd1;
                n_skip  = 1'b1;
            end
        end else begin
            n_skip  = 1'b0;
            do_lead = 1'b1;
        end

        if (do_lead) begin
            if (!b[7]) begin
                vals[cnt[0]] = {23'd0, b};
                reps[cnt[0]] = 1'b0;
                cnt          = cnt + 2'd1;
            end else if (!b[5]) begin
                n_partial = {26'd0, b[4:0]};
                n_pending = 3'd1;
            end else if (!b[4]) begin
                n_partial = {27'd0, b[3:0]};
                n_pending = 3'd2;
            end else if (!b[3]) begin
                n_partial = {28'd0, b[2:0]};
                n_pending = 3'd3;
            end else if (!b[2]) begin
                n_partial = {29'd0, b[1:0]};
                n_pending = 3'd4;
            end else begin
                n_partial = {30'd0, b[0]};
                n_pending = 3'd5;
            end
        end

        if (i_in_beat.end_of_string) begin
            if (n_pending != 3'd0) begin
                vals[cnt[0]] = REPL_CHAR;
                reps[cnt[0]] = 1'b1;
                cnt          = cnt + 2'd1;
            end
            n_pending = 3'd0;
            n_partial = '0;
            n_skip    = 1'b0;
        end

        ent.count               = cnt;
        ent.res0.code_point     = vals[0];
        ent.res0.is_replacement = reps[0];
        ent.res0.last_of_run    = (cnt == 2'd1);
        ent.res1.code_point     = vals[1];
        ent.res1.is_replacement = reps[1];
        ent.res1.last_of_run    = 1'b1;
    end

    assign o_push.valid = accept && (ent.count != 2'd0);
    assign o_push.entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_partial <= '0;
            r_skip    <= 1'b0;
        end else if (accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_skip    <= n_skip;
        end
    end

endmodule

// ===== hdl/usd_queue.sv =====
// Short queue between the front and back ends of the UTF-8 stream decoder.
// Holds one entry per byte that caused results. Depends on usd_pkg.
module usd_queue import usd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_push   i_push,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    t_entry                r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic                  do_push, do_pop;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/usd_back.sv =====
// Back end of the UTF-8 stream decoder: takes queue entries apart into single
// results and holds each in the output register. Depends on usd_pkg.
module usd_back import usd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    logic      r_valid, n_valid;
    t_out_beat r_beat,  n_beat;
    logic      r_sel,   n_sel;
    logic      load;

    assign load = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        n_sel   = r_sel;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_q_status.empty;
            n_beat  = r_sel ? i_head.res1 : i_head.res0;
            if (!i_q_status.empty) begin
                if (!r_sel && (i_head.count == 2'd2)) begin
                    n_sel = 1'b1;
                end else begin
                    n_sel = 1'b0;
                    o_pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front end, result queue and back end.
// Depends on usd_pkg, usd_front, usd_queue and usd_back.

// The decoder takes one byte per beat and turns legacy UTF-8 of up to six
// bytes into 31-bit code points, one result per output beat. A byte is
// accepted in every cycle while the four-entry result queue has room; a byte
// that completes a character, is plain ASCII or is a replacement case queues
// its results, and bytes that only extend a sequence queue nothing. The
// output side delivers one result per cycle unless the receiver stalls, so a
// byte that causes two results occupies the output longer and the queue
// absorbs the difference. A result is held in a queue slot and then in the
// output register after its byte is accepted. The last result of each byte
// is flagged with last_of_run, and replacements carry code point 63.
module utf8_stream_decoder import usd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_beat o_out_beat,
    input  logic      i_out_stall
);

    // The queue reports fullness to the front end, which stalls the input
    // on it, and emptiness to the back end, which pops one entry once all of
    // its results have been loaded into the output register.
    t_q_push   push;
    t_q_status q_status;
    t_entry    head;
    logic      pop;

    usd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push)
    );

    usd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    usd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== hdl/usd_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to its top level.
// Depends on usd_pkg and utf8_stream_decoder.
module usd_checker import usd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_beat o_out_beat,
    input logic      i_out_stall
);

    // A stalled output beat is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // Every replacement carries the question mark.
    a_repl_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.is_replacement |-> o_out_beat.code_point == REPL_CHAR)
        else $error("replacement with wrong code point");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Reset empties the queue, so input is taken right away.
    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind utf8_stream_decoder usd_checker u_chk (.*);

// ===== test/usd_decode_checker.sv =====
// Checker for the UTF-8 stream decoder: watches both channels, predicts the code points
// of every accepted byte and compares each delivered result. Depends on usd_pkg.
module usd_decode_checker import usd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_beat  i_in_beat,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_beat i_out_beat,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state as the prediction sees it.
    logic [2:0]  seq_left;
    logic [30:0] seq_bits;
    logic        drop_cont;

    t_out_beat byte_results[$];
    t_out_beat expected_results[$];
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic void queue_result(input logic [30:0] cp, input logic repl);
        t_out_beat r;
        r.code_point     = cp;
        r.is_replacement = repl;
        r.last_of_run    = 1'b0;
        byte_results = {byte_results, r};
    endfunction

    // A byte that is not a continuation byte: ASCII, or the lead of a new sequence.
    function automatic void open_sequence(input logic [7:0] b);
        if (b < 8'h80) begin
            queue_result({23'd0, b}, 1'b0);
        end else if (b < 8'he0) begin
            seq_bits = {26'd0, b[4:0]};
            seq_left = 3'd1;
        end else if (b < 8'hf0) begin
            seq_bits = {27'd0, b[3:0]};
            seq_left = 3'd2;
        end else if (b < 8'hf8) begin
            seq_bits = {28'd0, b[2:0]};
            seq_left = 3'd3;
        end else if (b < 8'hfc) begin
            seq_bits = {29'd0, b[1:0]};
            seq_left = 3'd4;
        end else begin
            seq_bits = {30'd0, b[0]};
            seq_left = 3'd5;
        end
    endfunction

    function automatic void predict_byte(input t_in_beat beat);
        logic is_cont;
        is_cont = (beat.data_byte[7:6] == 2'b10);
        byte_results.delete();
        if (seq_left != 3'd0) begin
            if (is_cont) begin
                seq_bits = {seq_bits[24:0], beat.data_byte[5:0]};
                seq_left = seq_left - 3'd1;
                if (seq_left == 3'd0) begin
                    queue_result(seq_bits, 1'b0);
                    seq_bits = '0;
                end
            end else begin
                queue_result(REPL_CHAR, 1'b1);
                seq_left = '0;
                seq_bits = '0;
                open_sequence(beat.data_byte);
            end
        end else if (is_cont) begin
            if (!drop_cont) begin
                queue_result(REPL_CHAR, 1'b1);
                drop_cont = 1'b1;
            end
        end else begin
            drop_cont = 1'b0;
            open_sequence(beat.data_byte);
        end
        if (beat.end_of_string) begin
            if (seq_left != 3'd0) begin
                queue_result(REPL_CHAR, 1'b1);
            end
            seq_left  = '0;
            seq_bits  = '0;
            drop_cont = 1'b0;
        end
        if (byte_results.size() > 0) begin
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        end
        foreach (byte_results[k]) begin
            expected_results = {expected_results, byte_results[k]};
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            seq_left  = '0;
            seq_bits  = '0;
            drop_cont = 1'b0;
            expected_results.delete();
        end else begin
            // A result leaves the block only after passing the queue and the output register, so taking
            // the input beat first never lets a fresh prediction meet its own result.
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_in_beat);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got cp=%h repl=%b last=%b",
                             $time, i_out_beat.code_point, i_out_beat.is_replacement,
                             i_out_beat.last_of_run);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_beat.code_point !== want.code_point
                        || i_out_beat.is_replacement !== want.is_replacement
                        || i_out_beat.last_of_run !== want.last_of_run) begin
                        $display({"%0t: mismatch: expected cp=%h repl=%b last=%b, ",
                                  "got cp=%h repl=%b last=%b"},
                                 $time, want.code_point, want.is_replacement,
                                 want.last_of_run, i_out_beat.code_point,
                                 i_out_beat.is_replacement, i_out_beat.last_of_run);
                        fail_total++;
                    end
                end
            end
        end
        o_waiting <= expected_results.size();
    end

endmodule

// ===== test/utf8_stream_decoder_test.sv =====
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus, result stalls
// and the verdict. Depends on usd_pkg, utf8_stream_decoder and usd_decode_checker.
module utf8_stream_decoder_test import usd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog counts cycles in which neither channel moves a beat. The longest
    // correct quiet stretch comes from the receiver's single long hold-off.
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 300;
    localparam int BYTE_TARGET    = 1250;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;
    logic      out_stall = 1'b0;

    int fail_count;
    int waiting;
    int idle_cycles = 0;
    int sent        = 0;
    bit quiet       = 1'b0;
    bit held_off    = 1'b0;

    // Bytes of the string being sent next; the last one carries end_of_string.
    logic [7:0] text_bytes[$];

    always #2 clk = ~clk;

    utf8_stream_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_beat   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_beat  (out_beat),
        .i_out_stall (out_stall)
    );

    usd_decode_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_beat    (in_beat),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_beat   (out_beat),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    // Idle lengths: mostly none, otherwise a short gap or, now and then, a long gap.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Lead byte for a sequence of the given length; six-byte leads cover 0xfc..0xff.
    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom());
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {6'b111111, r[1:0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom());
        return {2'b10, r[5:0]};
    endfunction

    // Offers one beat and returns at the falling edge after it was accepted. Entry is
    // always at a falling edge, so valid and the payload change only there and each
    // gets a single assignment per time step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= t_in_beat'{data_byte: b, end_of_string: eos};
        do @(posedge clk); while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_text();
        foreach (text_bytes[k]) begin
            send_byte(text_bytes[k], k == text_bytes.size() - 1);
        end
        text_bytes.delete();
    endtask

    // Appends one sequence of len bytes, leaving out the last cut continuation bytes.
    task automatic add_sequence(input int len, input int cut);
        text_bytes = {text_bytes, lead_byte(len)};
        repeat (len - 1 - cut) text_bytes = {text_bytes, cont_byte()};
    endtask

    // A random string: mostly well-formed characters of every length, mixed with
    // truncated sequences, runs of stray continuation bytes and arbitrary bytes.
    task automatic random_string();
        int n_chars;
        int kind;
        int len;
        n_chars = $urandom_range(1, 10);
        quiet   = ($urandom_range(0, 4) == 0);
        repeat (n_chars) begin
            kind = $urandom_range(0, 99);
            if (kind < 78) begin
                add_sequence($urandom_range(1, 6), 0);
            end else if (kind < 88) begin
                len = $urandom_range(2, 6);
                add_sequence(len, $urandom_range(1, len - 1));
            end else if (kind < 94) begin
                repeat ($urandom_range(1, 3)) text_bytes = {text_bytes, cont_byte()};
            end else begin
                text_bytes = {text_bytes, 8'($urandom())};
            end
        end
        send_text();
    endtask

    // Receiver: random stall runs, plus one long hold-off once enough bytes have been
    // sent, so the result queue fills and the block stalls its input side.
    initial begin : receiver
        int n;
        @(posedge rst_n);
        forever begin
            if (!held_off && sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            n = quiet ? 0 : idle_len();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings: ASCII extremes, a two-byte character, a six-byte
        // sequence on lead 0xff with all payload bits set, a stray continuation
        // followed by a dropped one, an interrupted sequence, a lead on the final
        // byte, a dropped continuation as the final byte after a stray one, an
        // interrupted sequence whose new lead is the final byte (two replacements),
        // and an overlong five-byte zero.
        text_bytes = '{8'h00, 8'h7f};
        send_text();
        text_bytes = '{8'hc3, 8'ha9};
        send_text();
        text_bytes = '{8'hff, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf};
        send_text();
        text_bytes = '{8'h80, 8'hbf, 8'h41};
        send_text();
        text_bytes = '{8'he2, 8'h41};
        send_text();
        text_bytes = '{8'hf0};
        send_text();
        text_bytes = '{8'h80, 8'h80};
        send_text();
        text_bytes = '{8'he2, 8'hc3};
        send_text();
        text_bytes = '{8'hf8, 8'h80, 8'h80, 8'h80, 8'h80};
        send_text();

        while (sent < BYTE_TARGET) random_string();
        in_valid <= 1'b0;

        // Drain: wait until the checker has no result outstanding before the verdict.
        while (waiting != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
